/* rtl/core/opra_pkg.sv */
// Shared types and constants of the running-average option payoff block.
// No dependencies; imported by every module of the block.
package opra_pkg;

	localparam int PRICE_W = 32;
	localparam int STEP_W  = 8;
	localparam int KIND_W  = 2;
	localparam int QCNT_W  = 6;

	localparam logic [KIND_W-1:0] KIND_PUT     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CALL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_AVG_CALL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_AVG_PUT = 2'd3;

	localparam logic REG_KIND   = 1'b0;
	localparam logic REG_STRIKE = 1'b1;

	typedef logic [PRICE_W-1:0] price_t;

	typedef struct packed {
		logic              emit;
		logic              overflow;
		logic [STEP_W-1:0] step_index;
	} opra_step_t;

	function automatic price_t clamp_sub(input price_t a, input price_t b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

/* rtl/core/option_payoff_running_average_top.sv */
// An item that opens a path gives no result; a put or call result passes the
// load and payoff states, and an average call or put result also passes the
// bit-serial divider that forms the average of the path. Items are taken
// one at a time; a finished result waits in the output register while the
// next item is accepted. Depends on opra_pkg, opra_accum and opra_div.
module option_payoff_running_average_top #(
	parameter int MAX_STEPS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic                         cfg_index,
	input  logic [opra_pkg::PRICE_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [opra_pkg::PRICE_W-1:0] price,
	input  logic                         path_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [opra_pkg::PRICE_W-1:0] payoff,
	output logic [opra_pkg::STEP_W-1:0]  step_index,
	output logic                         overflow
);
	import opra_pkg::*;

	localparam int SUM_W = PRICE_W + $clog2(MAX_STEPS + 1);
	localparam int CNT_W = $clog2(MAX_STEPS + 2);
	localparam int IDX_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;
	localparam logic [IDX_W-1:0] OVF_STEP = IDX_W'(MAX_STEPS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PAY  = 2'd3;

	logic [1:0]        state_q;
	logic [KIND_W-1:0] kind_q;
	price_t            strike_q;
	price_t            payoff_q;
	logic [STEP_W-1:0] step_q;
	logic              ovf_q;
	logic              out_valid_q;

	logic              accept;
	logic [SUM_W-1:0]  sum;
	logic [CNT_W-1:0]  count;
	price_t            price_held;
	opra_step_t        info;
	logic              div_start;
	logic              div_done;
	price_t            avg;
	price_t            pay_next;
	logic              out_free;
	logic              load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_start = (state_q == ST_LOAD) && info.emit && kind_q[1];
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_PAY) && out_free;

	opra_accum #(
		.MAX_STEPS(MAX_STEPS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.price     (price),
		.path_start(path_start),
		.sum       (sum),
		.count     (count),
		.price_held(price_held),
		.info      (info)
	);

	opra_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum),
		.divisor (count),
		.done    (div_done),
		.quotient(avg)
	);

	always_comb begin
		case (kind_q)
			KIND_PUT:      pay_next = clamp_sub(strike_q, price_held);
			KIND_CALL:     pay_next = clamp_sub(price_held, strike_q);
			KIND_AVG_CALL: pay_next = clamp_sub(avg, strike_q);
			KIND_AVG_PUT:  pay_next = clamp_sub(strike_q, avg);
			default:       pay_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_PUT;
			strike_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_KIND:   kind_q   <= cfg_data[KIND_W-1:0];
				REG_STRIKE: strike_q <= cfg_data;
				default:    kind_q   <= kind_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (!info.emit) begin
						state_q <= ST_IDLE;
					end else if (kind_q[1]) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_PAY;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PAY;
					end
				end
				ST_PAY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			payoff_q <= pay_next;
			step_q   <= info.step_index;
			ovf_q    <= info.overflow;
		end
	end

	assign out_valid  = out_valid_q;
	assign payoff     = payoff_q;
	assign step_index = step_q;
	assign overflow   = ovf_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("Divider finished outside the divide state.");

	a_load_has_path: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (count != '0) && info.emit)
		else $error("Result loaded without an open path.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(MAX_STEPS + 1))
		else $error("Sample count ran past its saturation value.");

	a_ovf_step: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && info.overflow |=> step_index == OVF_STEP[STEP_W-1:0])
		else $error("Saturated request shows the wrong step index.");

endmodule

/* rtl/core/opra_accum.sv */
// Path accumulator: running sum, sample count, step index and saturation flag.
// Depends on opra_pkg.
module opra_accum #(
	parameter int MAX_STEPS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  opra_pkg::price_t        price,
	input  logic                    path_start,
	output logic [31+$clog2(MAX_STEPS+1):0] sum,
	output logic [$clog2(MAX_STEPS+2)-1:0]  count,
	output opra_pkg::price_t        price_held,
	output opra_pkg::opra_step_t    info
);
	import opra_pkg::*;

	localparam int SUM_W = PRICE_W + $clog2(MAX_STEPS + 1);
	localparam int CNT_W = $clog2(MAX_STEPS + 2);
	localparam int IDX_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STEPS + 1);
	localparam logic [IDX_W-1:0] OVF_STEP = IDX_W'(MAX_STEPS - 1);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	price_t           price_q;
	opra_step_t       info_q;
	logic             open_path;
	logic             saturated;
	logic [IDX_W-1:0] cnt_ext;
	logic [IDX_W-1:0] step_next;

	assign open_path = path_start || (count_q == '0);
	assign saturated = (count_q == CNT_MAX);
	assign cnt_ext   = IDX_W'(count_q);
	assign step_next = cnt_ext - IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			info_q  <= '0;
		end else if (accept) begin
			if (open_path) begin
				sum_q   <= SUM_W'(price);
				count_q <= CNT_W'(1);
				info_q  <= '0;
			end else if (saturated) begin
				info_q.emit       <= 1'b1;
				info_q.overflow   <= 1'b1;
				info_q.step_index <= OVF_STEP[STEP_W-1:0];
			end else begin
				sum_q   <= sum_q + SUM_W'(price);
				count_q <= count_q + CNT_W'(1);
				info_q.emit       <= 1'b1;
				info_q.overflow   <= 1'b0;
				info_q.step_index <= step_next[STEP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= price;
		end
	end

	assign sum        = sum_q;
	assign count      = count_q;
	assign price_held = price_q;
	assign info       = info_q;

endmodule

/* rtl/core/opra_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// The quotient is known to fit 32 bits. Depends on opra_pkg.
module opra_div #(
	parameter int SUM_W = 41,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output opra_pkg::price_t quotient
);
	import opra_pkg::*;

	localparam int HI_W = SUM_W - PRICE_W;

	logic [CNT_W-1:0]  rem_q;
	price_t            quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[PRICE_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == QCNT_W'(1));
			if (start) begin
				cnt_q <= QCNT_W'(PRICE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CNT_W'(dividend[SUM_W-1:PRICE_W]);
			quo_q <= dividend[PRICE_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[PRICE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
